// ===== rtl/wstq_pkg.sv =====
// shared types and constants of the work stealing task queues
package wstq_pkg;

  localparam int DEF_PROCESSORS  = 8;
  localparam int DEF_QUEUE_DEPTH = 256;

  // holds an active count up to the largest processor count
  localparam int N_W = 7;

  localparam logic       OP_ASSIGN    = 1'b0;
  localparam logic       OP_EXEC      = 1'b1;
  localparam logic [7:0] EMPTY_MARK   = 8'd59;
  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_PICK,
    S_STEAL,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ===== rtl/wstq_if.sv =====
// channel interfaces: command, result and configuration words
interface wstq_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [2:0] proc_id;
  logic [7:0] task_code;

  modport source (output valid, output opcode, output proc_id, output task_code,
                  input ready);
  modport sink   (input valid, input opcode, input proc_id, input task_code,
                  output ready);
endinterface

interface wstq_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [7:0] executed_task;
  logic [2:0] source_processor;
  logic       stolen;
  logic       none_available;

  modport source (output valid, output accepted, output executed_task,
                  output source_processor, output stolen, output none_available,
                  input ready);
  modport sink   (input valid, input accepted, input executed_task,
                  input source_processor, input stolen, input none_available,
                  output ready);
endinterface

interface wstq_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] active_processors;

  modport source (output valid, output active_processors, input ready);
  modport sink   (input valid, input active_processors, output ready);
endinterface

// ===== rtl/wstq_ram.sv =====
// generic single port ram with registered read
module wstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/work_stealing_task_queues_core.sv =====
// top level: per-processor task deques with work stealing
//
// cmd carries one word per command: opcode assign or exec, the addressed
// processor and, for assign, the task byte. rsp returns exactly one word
// per command. cfg writes active_processors (takes effect on the next
// command; the user must write it only while the block is idle, which the
// block does not enforce); cfg.ready is high outside reset. cmd.ready is
// high only while the sequencer is idle and out of reset, so one command is
// in work at a time. An assign or a command to an inactive processor goes
// through S_LOOK and S_DONE into the output register, an exec served from
// the processor's own deque through S_LOOK, S_READ and S_DONE. An exec that
// must steal walks the queue counts in S_SCAN one processor per cycle with a
// single compare unit, then goes through S_PICK, S_STEAL, S_READ and S_DONE,
// or from S_PICK straight to S_DONE when every deque is empty.
// The task store is one single port ram with registered read, addressed by
// processor and slot. A finished result waits in the output register while
// rsp is stalled; the next command is still accepted and is held at its end
// until the register frees. Reset empties every deque, sets
// active_processors to 8 and drops any pending result; no clearing pass.
module work_stealing_task_queues_core
  import wstq_pkg::*;
#(
  parameter int PROCESSORS  = DEF_PROCESSORS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  wstq_cmd_if.sink       cmd,
  wstq_rsp_if.source     rsp,
  wstq_cfg_if.sink       cfg
);

  localparam int PW        = (PROCESSORS > 1) ? $clog2(PROCESSORS) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = PROCESSORS * (2 ** PTR_W);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [N_W-1:0]   N_MAX    = N_W'(PROCESSORS);

  state_t state, state_next;

  logic [3:0]       active;
  logic [N_W-1:0]   n_eff;

  logic             op;
  logic [2:0]       p_reg;
  logic [7:0]       code;
  logic [PW-1:0]    cur;
  logic [PW-1:0]    best;
  logic [CNT_W-1:0] bestc;

  logic [CNT_W-1:0] count [PROCESSORS];
  logic [PTR_W-1:0] head  [PROCESSORS];
  logic [PTR_W-1:0] tail  [PROCESSORS];

  logic             res_accepted;
  logic [7:0]       res_task;
  logic [2:0]       res_src;
  logic             res_stolen;
  logic             res_none;

  logic             out_valid;
  logic             out_accepted;
  logic [7:0]       out_task;
  logic [2:0]       out_src;
  logic             out_stolen;
  logic             out_none;

  logic [PW+2:0]    p_wide;
  logic [PW+2:0]    cur_wide;
  logic [N_W-1:0]   cur_ext;
  logic             p_active;
  logic             scan_last;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] tail_dec;
  logic [PTR_W-1:0] head_inc;
  logic             out_free;

  logic                mem_we;
  logic [PW+PTR_W-1:0] mem_addr_full;
  logic [MEM_AW-1:0]   mem_addr;
  logic [7:0]          mem_rdata;

  // effective processor count
  always_comb begin
    if (active == 4'd0) begin
      n_eff = N_W'(1);
    end else if ({3'b000, active} > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = {3'b000, active};
    end
  end

  assign p_wide    = {{PW{1'b0}}, cmd.proc_id};
  assign cur_wide  = {3'b000, cur};
  assign cur_ext   = {{(N_W - PW){1'b0}}, cur};
  assign p_active  = ({4'b0000, p_reg} < n_eff);
  assign scan_last = ((cur_ext + N_W'(1)) >= n_eff);
  assign tail_inc  = (tail[cur] == PTR_LAST) ? '0 : tail[cur] + PTR_W'(1);
  assign tail_dec  = (tail[cur] == '0) ? PTR_LAST : tail[cur] - PTR_W'(1);
  assign head_inc  = (head[cur] == PTR_LAST) ? '0 : head[cur] + PTR_W'(1);
  assign out_free  = !out_valid || rsp.ready;

  assign cmd.ready = (state == S_IDLE) && !rst;
  assign cfg.ready = !rst;

  // next state and ram control
  always_comb begin
    state_next    = state;
    mem_we        = 1'b0;
    mem_addr_full = {cur, head[cur]};
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!p_active) begin
          state_next = S_DONE;
        end else if (op == OP_ASSIGN) begin
          mem_addr_full = {cur, tail[cur]};
          mem_we        = (count[cur] < CNT_FULL);
          state_next    = S_DONE;
        end else if (count[cur] != '0) begin
          state_next = S_READ;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        state_next = (bestc == '0) ? S_DONE : S_STEAL;
      end
      S_STEAL: begin
        mem_addr_full = {cur, tail_dec};
        state_next    = S_READ;
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign mem_addr = mem_addr_full[MEM_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACTIVE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      active <= cfg.active_processors;
    end
  end

  // queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROCESSORS; i++) begin
        count[i] <= '0;
        head[i]  <= '0;
        tail[i]  <= '0;
      end
    end else begin
      case (state)
        S_LOOK: begin
          if (p_active) begin
            if (op == OP_ASSIGN) begin
              if (count[cur] < CNT_FULL) begin
                tail[cur]  <= tail_inc;
                count[cur] <= count[cur] + CNT_W'(1);
              end
            end else if (count[cur] != '0) begin
              head[cur]  <= head_inc;
              count[cur] <= count[cur] - CNT_W'(1);
            end
          end
        end
        S_STEAL: begin
          tail[cur]  <= tail_dec;
          count[cur] <= count[cur] - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // command latch, search unit and result word
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op           <= cmd.opcode;
        p_reg        <= cmd.proc_id;
        code         <= cmd.task_code;
        cur          <= p_wide[PW-1:0];
        res_accepted <= 1'b0;
        res_task     <= 8'd0;
        res_src      <= 3'd0;
        res_stolen   <= 1'b0;
        res_none     <= 1'b0;
      end
      S_LOOK: begin
        best  <= '0;
        bestc <= '0;
        if (!p_active) begin
          if (op == OP_EXEC) begin
            res_task <= EMPTY_MARK;
            res_none <= 1'b1;
          end
        end else if (op == OP_ASSIGN) begin
          res_accepted <= (count[cur] < CNT_FULL);
        end else if (count[cur] != '0) begin
          res_src <= cur_wide[2:0];
        end else begin
          cur <= '0;
        end
      end
      S_SCAN: begin
        if (count[cur] > bestc) begin
          bestc <= count[cur];
          best  <= cur;
        end
        if (!scan_last) begin
          cur <= cur + PW'(1);
        end
      end
      S_PICK: begin
        cur <= best;
        if (bestc == '0) begin
          res_task <= EMPTY_MARK;
          res_none <= 1'b1;
        end
      end
      S_STEAL: begin
        res_src    <= cur_wide[2:0];
        res_stolen <= 1'b1;
      end
      S_READ: begin
        res_task <= mem_rdata;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_accepted <= res_accepted;
      out_task     <= res_task;
      out_src      <= res_src;
      out_stolen   <= res_stolen;
      out_none     <= res_none;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.accepted         = out_accepted;
  assign rsp.executed_task    = out_task;
  assign rsp.source_processor = out_src;
  assign rsp.stolen           = out_stolen;
  assign rsp.none_available   = out_none;

  wstq_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (code),
    .rdata (mem_rdata)
  );

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command accepted while another is in work");

  a_none_marker: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.none_available) |-> (rsp.executed_task == EMPTY_MARK && !rsp.stolen))
    else $error("empty result without marker");

  a_assign_excl: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.accepted) |-> (!rsp.stolen && !rsp.none_available))
    else $error("assign result carries exec flags");

  a_write_assign: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_LOOK && op == OP_ASSIGN && p_active))
    else $error("task store written outside an assign");

  a_steal_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEAL) |-> (count[cur] != '0 && $past(state) == S_PICK))
    else $error("steal from an empty deque");

endmodule
